// ----- hdl/fcc_pkg.sv -----
// ----------------------------------------------------------------------------
// fcc_pkg: shared types and constants of the flash coincidence clusterer
// Holds field widths, register offsets, the cluster table entry and the
// controller state type.
// ----------------------------------------------------------------------------
package fcc_pkg;

  localparam int unsigned MaxClustersDefault = 16;

  localparam int unsigned TimeW    = 24;
  localparam int unsigned ZW       = 20;
  localparam int unsigned TimeWinW = 23;
  localparam int unsigned ZWinW    = 19;
  localparam int unsigned MembersW = 8;
  localparam int unsigned IdW      = 4;

  localparam logic [TimeWinW-1:0] TimeWinReset = 23'd16;
  localparam logic [ZWinW-1:0]    ZWinReset    = 19'd6400;
  localparam logic [MembersW-1:0] MembersMax   = 8'd255;
  localparam logic [MembersW-1:0] MembersOne   = 8'd1;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_TIME_WINDOW = 1'b0,
    REG_Z_WINDOW    = 1'b1
  } reg_idx_e;

  // One cluster table entry: the seed flash and the member count
  typedef struct packed {
    logic signed [TimeW-1:0] seed_time;
    logic signed [ZW-1:0]    seed_z;
    logic                    seed_cath;
    logic [MembersW-1:0]     members;
  } entry_t;

  // Result of one flash
  typedef struct packed {
    logic [IdW-1:0]      cluster_id;
    logic                opened_new;
    logic [MembersW-1:0] member_count;
    logic                overflow;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

endpackage

// ----- hdl/flash_coincidence_clusterer.sv -----
// ----------------------------------------------------------------------------
// flash_coincidence_clusterer: greedy first-fit clustering of light flashes
// Scans the seed table held in one synchronous memory, joins the first
// matching cluster or opens a new one, and reports one result per flash.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one flash per item:
//   start_event, pulse_time, flash_z, is_cathode. Output channel
//   (out_valid_o / out_ready_i) returns one result item per flash:
//   cluster_id, opened_new, member_count, overflow.
//   Timing: one item is worked on at a time. After acceptance the scan
//   reads one table entry per cycle from the seed memory (one read port,
//   registered read data), stops at the first matching entry or after the
//   last open entry, and passes the result through the result register to
//   the output register; the next item is taken once the result has moved
//   to the output register.
//   Reset: the open cluster count clears and the windows take their reset
//   values (16 and 6400). Table memory is not cleared; only entries below
//   the open count are ever compared. start_event empties the table at once.
//   Stall: a finished result sits in the output register; the block holds
//   the next result in its result stage until the register frees up.
//   Configuration: APB writes at offset 0 (time_window) and 4 (z_window),
//   only while the block is idle, a rule for the user that is not enforced.
// ----------------------------------------------------------------------------
module flash_coincidence_clusterer
  import fcc_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = MaxClustersDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // flash input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 start_event_i,
  input  logic signed [23:0]   pulse_time_i,
  input  logic signed [19:0]   flash_z_i,
  input  logic                 is_cathode_i,
  // result output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           cluster_id_o,
  output logic                 opened_new_o,
  output logic [7:0]           member_count_o,
  output logic                 overflow_o
);

  localparam int unsigned IdxW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned CntW = $clog2(MAX_CLUSTERS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_CLUSTERS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TimeWinW-1:0] time_win_q;
  logic [ZWinW-1:0]    z_win_q;
  logic                cfg_we;
  reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_win_q <= TimeWinReset;
      z_win_q    <= ZWinReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TIME_WINDOW: time_win_q <= pwdata[TimeWinW-1:0];
        REG_Z_WINDOW:    z_win_q    <= pwdata[ZWinW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TIME_WINDOW: prdata = {{(32-TimeWinW){1'b0}}, time_win_q};
      REG_Z_WINDOW:    prdata = {{(32-ZWinW){1'b0}}, z_win_q};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and item registers
  // --------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [CntW-1:0]       open_q, open_d;      // open clusters
  logic [CntW-1:0]       idx_q, idx_d;        // next entry to read
  logic                  cmp_vld_q;           // rdata_q holds a valid entry
  logic [IdxW-1:0]       cmp_idx_q;           // entry held in rdata_q
  logic signed [TimeW-1:0] item_time_q;
  logic signed [ZW-1:0]  item_z_q;
  logic                  item_cath_q;
  result_t               res_q, res_d;
  logic                  res_we;
  logic                  in_acc;
  logic                  rd_en;
  logic                  out_load;

  // seed table memory
  entry_t                mem_q [MAX_CLUSTERS];
  entry_t                rdata_q;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  entry_t                mem_wdata;
  logic [IdxW-1:0]       mem_raddr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign rd_en      = (state_q == ST_SCAN) && (idx_q < open_q);
  assign mem_raddr  = idx_q[IdxW-1:0];

  // --------------------------------------------------------------------------
  // Seed comparison on the entry read last cycle
  // --------------------------------------------------------------------------
  logic signed [TimeW:0] t_diff;
  logic signed [ZW:0]    z_diff;
  logic [TimeW:0]        t_abs;
  logic [ZW:0]           z_abs;
  logic                  hit;
  logic                  match;
  logic                  scan_end;

  always_comb begin
    t_diff = {rdata_q.seed_time[TimeW-1], rdata_q.seed_time}
           - {item_time_q[TimeW-1], item_time_q};
    z_diff = {rdata_q.seed_z[ZW-1], rdata_q.seed_z}
           - {item_z_q[ZW-1], item_z_q};
    t_abs  = t_diff[TimeW] ? (TimeW+1)'(-t_diff) : t_diff;
    z_abs  = z_diff[ZW] ? (ZW+1)'(-z_diff) : z_diff;
    hit    = (t_abs <= {{(TimeW+1-TimeWinW){1'b0}}, time_win_q})
          && (z_abs <= {{(ZW+1-ZWinW){1'b0}}, z_win_q})
          && (rdata_q.seed_cath != item_cath_q);
  end

  assign match    = (state_q == ST_SCAN) && cmp_vld_q && hit;
  assign scan_end = (state_q == ST_SCAN) && (idx_q == open_q) && !match;
  assign out_load = (state_q == ST_EMIT) && (!out_valid_o || out_ready_i);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: if (match || scan_end) state_d = ST_EMIT;
      ST_EMIT: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control: read-modify-write of the table, result, counters
  // --------------------------------------------------------------------------
  always_comb begin
    open_d    = open_q;
    idx_d     = idx_q;
    mem_we    = 1'b0;
    mem_waddr = cmp_idx_q;
    mem_wdata = rdata_q;
    res_we    = 1'b0;
    res_d     = res_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        // start of event: empty the table before placing this flash
        if (in_acc && start_event_i) open_d = '0;
      end
      ST_SCAN: begin
        if (rd_en) idx_d = idx_q + 1'b1;
        if (match) begin
          // join: bump the member count, saturating
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_q;
          if (rdata_q.members != MembersMax) begin
            mem_wdata.members = rdata_q.members + 1'b1;
          end
          res_we             = 1'b1;
          res_d.cluster_id   = IdW'(cmp_idx_q);
          res_d.opened_new   = 1'b0;
          res_d.member_count = mem_wdata.members;
          res_d.overflow     = 1'b0;
        end else if (scan_end) begin
          res_we = 1'b1;
          if (open_q < CntMax) begin
            // open a new cluster seeded by this flash
            mem_we              = 1'b1;
            mem_waddr           = open_q[IdxW-1:0];
            mem_wdata.seed_time = item_time_q;
            mem_wdata.seed_z    = item_z_q;
            mem_wdata.seed_cath = item_cath_q;
            mem_wdata.members   = MembersOne;
            open_d              = open_q + 1'b1;
            res_d.cluster_id    = IdW'(open_q[IdxW-1:0]);
            res_d.opened_new    = 1'b1;
            res_d.member_count  = MembersOne;
            res_d.overflow      = 1'b0;
          end else begin
            // table full: drop the flash
            res_d.cluster_id   = '0;
            res_d.opened_new   = 1'b0;
            res_d.member_count = '0;
            res_d.overflow     = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      open_q      <= '0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q   <= state_d;
      open_q    <= open_d;
      idx_q     <= idx_d;
      cmp_vld_q <= rd_en;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_time_q <= pulse_time_i;
      item_z_q    <= flash_z_i;
      item_cath_q <= is_cathode_i;
    end
    if (rd_en) cmp_idx_q <= mem_raddr;
    if (res_we) res_q <= res_d;
    if (out_load) begin
      cluster_id_o   <= res_q.cluster_id;
      opened_new_o   <= res_q.opened_new;
      member_count_o <= res_q.member_count;
      overflow_o     <= res_q.overflow;
    end
  end

  // seed table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[mem_raddr];
  end

endmodule
